FILE: sv/gpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared constants and the table generator for the gaussian peak evaluator.
// ----------------------------------------------------------------------------
package gpe_pkg;

	localparam int EXP_TABLE_BITS = 8;     // default table index width
	localparam int QBITS          = 22;    // quotient bits kept from the divide
	localparam int FRAC           = 16;    // Q16.16 fraction bits
	localparam logic [31:0] AREA_K = 32'd2285925518;  // sqrt(pi/ln2), Q2.30

	typedef enum logic [1:0] {
		REG_CENTER = 2'd0,
		REG_HWIDTH = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned res;
		longint unsigned bt;
		n   = n_in;
		res = 0;
		bt  = 64'd1 << 62;
		while (bt > n) bt = bt >> 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n   = n - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(-i / 2^bits) in Q1.32, built from repeated square roots of 1/2
	function automatic logic [32:0] exp_entry(input int idx, input int bits);
		longint unsigned p;
		longint unsigned s;
		p = 64'd1 << 32;
		s = 64'd1 << 31;
		if (idx >= (1 << bits)) return 33'h0_8000_0000;
		for (int j = 1; j <= bits; j++) begin
			s = isqrt64(s << 32);
			if (((idx >> (bits - j)) & 1) != 0) p = (p * s) >> 32;
		end
		return p[32:0];
	endfunction

endpackage

FILE: sv/gaussian_peak_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_peak_evaluator
// Pipelined Q16.16 gaussian peak: curve value, running sum and peak area.
// ----------------------------------------------------------------------------
// Usage:
//   Write center_position (0), half_width (1) and peak_height (2) through
//   cfg_we / cfg_index / cfg_data while no beat is in flight.
//   A sample beat (sample_x, sum_in) is taken at each edge with start high;
//   busy stays low, so one beat per cycle is sustained.
//   Results come out in order after the accepting edge, marked by
//   done for exactly one cycle: curve_value, sum_out, peak_area, width_zero.
//   The pipeline holds the restoring divider, one quotient bit per stage
//   (22 stages), plus the subtract stage, the squaring multiplier, the table
//   lookup, the interpolation multiplier, the shift, the height multiplier
//   and the output register.
//   The area path runs off the registers in its own short pipeline and is
//   settled long before the first result of a new setting appears.
//   Reset clears all valid bits and loads the register defaults
//   (center 0, half width 1.0, height 1.0). The receiver cannot stall.
// ----------------------------------------------------------------------------
module gaussian_peak_evaluator #(
	parameter int EXP_TABLE_BITS = gpe_pkg::EXP_TABLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sum_in,
	output logic               done,
	output logic signed [31:0] curve_value,
	output logic signed [31:0] sum_out,
	output logic signed [47:0] peak_area,
	output logic               width_zero
);

	localparam int QB    = gpe_pkg::QBITS;
	localparam int SH    = gpe_pkg::FRAC - EXP_TABLE_BITS;
	localparam int TBL_N = (1 << EXP_TABLE_BITS) + 1;

	// ---------------- configuration ----------------
	logic [31:0] center_q, hwidth_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 32'd0;
			hwidth_q <= 32'd65536;
			height_q <= 32'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				gpe_pkg::REG_CENTER: center_q <= cfg_data;
				gpe_pkg::REG_HWIDTH: hwidth_q <= cfg_data;
				gpe_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [31:0] hmag, amag;
	logic        a_neg, h_zero;
	assign hmag   = hwidth_q[31] ? 32'(-hwidth_q) : hwidth_q;
	assign amag   = height_q[31] ? 32'(-height_q) : height_q;
	assign a_neg  = height_q[31];
	assign h_zero = (hwidth_q == 32'd0);

	assign busy = 1'b0;

	// ---------------- area path ----------------
	logic [63:0] ar_p_q, ar_hi_q, ar_lo_q;
	logic [47:0] area_q;
	logic [63:0] ar_sum;

	assign ar_sum = ar_hi_q + {32'd0, ar_lo_q[63:32]} + 64'd8192;

	always_ff @(posedge clk) begin
		ar_p_q  <= 64'(amag) * 64'(hmag);
		ar_hi_q <= 64'(ar_p_q[63:32]) * 64'(gpe_pkg::AREA_K);
		ar_lo_q <= 64'(ar_p_q[31:0]) * 64'(gpe_pkg::AREA_K);
		if (ar_sum[63:14] >= 50'(64'd1 << 47))
			area_q <= a_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		else
			area_q <= a_neg ? 48'(-ar_sum[61:14]) : ar_sum[61:14];
	end

	// ---------------- stage 1: distance ----------------
	logic signed [32:0] diff_x;
	logic [32:0]        dmag;
	assign diff_x = 33'(signed'(sample_x)) - 33'(signed'(center_q));
	assign dmag   = diff_x[32] ? 33'(-diff_x) : diff_x;

	// divider step arrays, entry 0 is loaded by stage 1
	logic          dv_vld_s2 [0:QB];
	logic [31:0]   dv_rem_s2 [0:QB];
	logic [5:0]    dv_dlo_s2 [0:QB];
	logic [QB-1:0] dv_quo_s2 [0:QB];
	logic          dv_big_s2 [0:QB];
	logic [31:0]   dv_sum_s2 [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld_s2[0] <= 1'b0;
		else         dv_vld_s2[0] <= start;
	end

	always_ff @(posedge clk) begin
		dv_rem_s2[0] <= {5'd0, dmag[32:6]};
		dv_dlo_s2[0] <= dmag[5:0];
		dv_quo_s2[0] <= '0;
		// u >= 2^6 means the quotient needs more than QB bits
		dv_big_s2[0] <= ({5'd0, dmag} >= {hmag, 6'd0});
		dv_sum_s2[0] <= sum_in;
	end

	// ---------------- restoring divide, one bit per stage ----------------
	for (genvar k = 1; k <= QB; k++) begin : g_div
		localparam int BP = QB - k;
		logic        nb;
		logic [32:0] trial;
		logic        ge;

		if (BP >= gpe_pkg::FRAC) begin : g_bit
			assign nb = dv_dlo_s2[k-1][BP-gpe_pkg::FRAC];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign trial = {dv_rem_s2[k-1], nb};
		assign ge    = (trial >= {1'b0, hmag});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld_s2[k] <= 1'b0;
			else         dv_vld_s2[k] <= dv_vld_s2[k-1];
		end

		always_ff @(posedge clk) begin
			dv_rem_s2[k] <= ge ? 32'(trial - {1'b0, hmag}) : trial[31:0];
			dv_quo_s2[k] <= {dv_quo_s2[k-1][QB-2:0], ge};
			dv_dlo_s2[k] <= dv_dlo_s2[k-1];
			dv_big_s2[k] <= dv_big_s2[k-1];
			dv_sum_s2[k] <= dv_sum_s2[k-1];
		end
	end

	// ---------------- exponent table ----------------
	logic [32:0] exp_tbl [0:TBL_N-1];
	for (genvar t = 0; t < TBL_N; t++) begin : g_tbl
		localparam logic [32:0] TV = gpe_pkg::exp_entry(t, EXP_TABLE_BITS);
		assign exp_tbl[t] = TV;
	end

	// ---------------- stage 3: square ----------------
	logic            vld_s3, kill_s3;
	logic [2*QB-1:0] sq_s3;
	logic [31:0]     sum_s3;

	// ---------------- stage 4: lookup ----------------
	logic        vld_s4, kill_s4;
	logic [4:0]  n_s4;
	logic [SH-1:0] r_s4;
	logic [32:0] t0_s4, t1_s4;
	logic [31:0] sum_s4;

	logic [27:0]                 u2;
	logic [EXP_TABLE_BITS-1:0]   tidx;
	assign u2   = sq_s3[43:16];
	assign tidx = u2[15:SH];

	// ---------------- stage 5: interpolation product ----------------
	logic           vld_s5, kill_s5;
	logic [4:0]     n_s5;
	logic [32:0]    t0_s5;
	logic [32+SH:0] ip_s5;
	logic [31:0]    sum_s5;

	// ---------------- stage 6: shift ----------------
	logic        vld_s6, kill_s6;
	logic [32:0] g_s6;
	logic [31:0] sum_s6;

	// ---------------- stage 7: height product ----------------
	logic        vld_s7, kill_s7;
	logic [64:0] hp_s7;
	logic [31:0] sum_s7;

	logic [32:0] m_val;
	assign m_val = t0_s5 - 33'(ip_s5 >> SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s3 <= dv_vld_s2[QB];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done   <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		sq_s3   <= (2*QB)'(dv_quo_s2[QB]) * (2*QB)'(dv_quo_s2[QB]);
		kill_s3 <= dv_big_s2[QB] | h_zero;
		sum_s3  <= dv_sum_s2[QB];

		// u^2 at or beyond 32 gives zero
		kill_s4 <= kill_s3 | (u2[27:21] != 7'd0);
		n_s4    <= u2[20:16];
		r_s4    <= u2[SH-1:0];
		t0_s4   <= exp_tbl[tidx];
		t1_s4   <= exp_tbl[(EXP_TABLE_BITS+1)'(tidx) + 1'b1];
		sum_s4  <= sum_s3;

		kill_s5 <= kill_s4;
		n_s5    <= n_s4;
		t0_s5   <= t0_s4;
		ip_s5   <= (33+SH)'(t0_s4 - t1_s4) * (33+SH)'(r_s4);
		sum_s5  <= sum_s4;

		kill_s6 <= kill_s5;
		g_s6    <= m_val >> n_s5;
		sum_s6  <= sum_s5;

		kill_s7 <= kill_s6;
		hp_s7   <= 65'(amag) * 65'(g_s6);
		sum_s7  <= sum_s6;
	end

	// ---------------- output stage ----------------
	logic [64:0]        hp_rnd;
	logic [32:0]        mag;
	logic signed [31:0] y_val;
	logic signed [32:0] sum_wide;

	assign hp_rnd = hp_s7 + 65'(64'd1 << 31);
	assign mag    = hp_rnd[64:32];

	always_comb begin
		if (kill_s7)
			y_val = 32'sd0;
		else if (a_neg)
			y_val = 32'(-mag);
		else if (mag > 33'h0_7FFF_FFFF)
			y_val = 32'sh7FFF_FFFF;
		else
			y_val = mag[31:0];
	end

	assign sum_wide = 33'(signed'(sum_s7)) + 33'(y_val);

	always_ff @(posedge clk) begin
		curve_value <= y_val;
		if (sum_wide[32] != sum_wide[31])
			sum_out <= sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else
			sum_out <= sum_wide[31:0];
		peak_area  <= area_q;
		width_zero <= h_zero;
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_peak_evaluator: a local fixed point model
// predicts curve value, saturated sum, peak area and the zero-width flag for
// every sample beat; a monitor compares each done beat against the oldest
// prediction. Directed corner cases first, then random sweeps over settings.
// ----------------------------------------------------------------------------
module tb;

	localparam int TB_BITS = gpe_pkg::EXP_TABLE_BITS;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam longint CYCLE_LIMIT = 600000;
	localparam logic [63:0] GAUSS_K = 64'd2285925518;

	typedef struct packed {
		logic signed [31:0] curve;
		logic signed [31:0] sum;
		logic signed [47:0] area;
		logic               wz;
	} peak_beat_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               start = 0;
	logic               busy;
	logic signed [31:0] sample_x = '0;
	logic signed [31:0] sum_in = '0;
	logic               done;
	logic signed [31:0] curve_value;
	logic signed [31:0] sum_out;
	logic signed [47:0] peak_area;
	logic               width_zero;

	gaussian_peak_evaluator dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	longint unsigned    pow_table [0:(1 << TB_BITS)];
	logic signed [31:0] mdl_center = 0;
	logic signed [31:0] mdl_hwidth = 32'sd65536;
	logic signed [31:0] mdl_height = 32'sd65536;
	peak_beat_t         pending_peaks [$];
	int                 mismatches = 0;
	int                 beats_sent = 0;
	int                 beats_seen = 0;
	int                 settings_used = 0;
	bit                 quiet = 0;
	longint             cycles = 0;

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned n, r, b;
		n = v;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic fill_pow_table();
		longint unsigned p, s;
		for (int i = 0; i < (1 << TB_BITS); i++) begin
			p = 64'd1 << 32;
			s = 64'd1 << 31;
			for (int j = 1; j <= TB_BITS; j++) begin
				s = int_sqrt(s << 32);
				if (((i >> (TB_BITS - j)) & 1) != 0) p = (p * s) >> 32;
			end
			pow_table[i] = p;
		end
		pow_table[1 << TB_BITS] = 64'd1 << 31;
	endtask

	function automatic peak_beat_t predict_peak(input logic signed [31:0] x,
			input logic signed [31:0] s_in);
		peak_beat_t      r;
		longint          d, y, sm;
		longint unsigned hmag, amag, dmag, q, u2, n, f, i, rem, t0, t1, m, g, mag;
		longint unsigned p, hi, lo, am;
		int              sh;
		sh   = 16 - TB_BITS;
		hmag = (mdl_hwidth < 0) ? -longint'(mdl_hwidth) : longint'(mdl_hwidth);
		amag = (mdl_height < 0) ? -longint'(mdl_height) : longint'(mdl_height);
		y    = 0;
		r.wz = (hmag == 0);
		if (hmag != 0) begin
			d    = longint'(x) - longint'(mdl_center);
			dmag = (d < 0) ? -d : d;
			q    = (dmag << 16) / hmag;
			if (q < (64'd1 << 22)) begin
				u2 = (q * q) >> 16;
				if (u2 < (64'd32 << 16)) begin
					n   = u2 >> 16;
					f   = u2 & 64'hFFFF;
					i   = f >> sh;
					rem = f & ((64'd1 << sh) - 1);
					t0  = pow_table[i];
					t1  = pow_table[i + 1];
					m   = t0 - (((t0 - t1) * rem) >> sh);
					g   = m >> n;
					mag = (amag * g + (64'd1 << 31)) >> 32;
					if (mdl_height < 0)
						y = (mag > (64'd1 << 31)) ? -(64'sd1 <<< 31) : -longint'(mag);
					else
						y = (mag > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(mag);
				end
			end
		end
		sm = longint'(s_in) + y;
		if (sm > 64'sh7FFF_FFFF) sm = 64'sh7FFF_FFFF;
		if (sm < -(64'sd1 <<< 31)) sm = -(64'sd1 <<< 31);
		p  = amag * hmag;
		hi = (p >> 32) * GAUSS_K;
		lo = (p & 64'hFFFF_FFFF) * GAUSS_K;
		am = (hi + (lo >> 32) + 64'd8192) >> 14;
		if (mdl_height < 0)
			r.area = (am >= (64'd1 << 47)) ? -(48'sd1 <<< 47) : -am[47:0];
		else
			r.area = (am >= (64'd1 << 47)) ? 48'sh7FFF_FFFF_FFFF : am[47:0];
		r.curve = y[31:0];
		r.sum   = sm[31:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: failure");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		peak_beat_t e;
		if (arst_n && done) begin
			beats_seen++;
			if (pending_peaks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("tb: unexpected result beat");
			end else begin
				e = pending_peaks.pop_front();
				if (e.curve !== curve_value || e.sum !== sum_out ||
						e.area !== peak_area || e.wz !== width_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch exp c=%0d s=%0d a=%0d z=%0b got c=%0d s=%0d a=%0d z=%0b",
							e.curve, e.sum, e.area, e.wz,
							curve_value, sum_out, peak_area, width_zero);
				end
			end
		end
	end

	task automatic wait_drained();
		start <= 0;
		while (pending_peaks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after its last write
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we    <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			gpe_pkg::REG_CENTER: mdl_center = val;
			gpe_pkg::REG_HWIDTH: mdl_hwidth = val;
			gpe_pkg::REG_HEIGHT: mdl_height = val;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [31:0] c, input logic [31:0] h,
			input logic [31:0] a);
		wait_drained();
		write_reg(gpe_pkg::REG_CENTER, c);
		write_reg(gpe_pkg::REG_HWIDTH, h);
		write_reg(gpe_pkg::REG_HEIGHT, a);
		cfg_we <= 0;
		settings_used++;
	endtask

	task automatic send_sample(input logic [31:0] x, input logic [31:0] s);
		start    <= 1;
		sample_x <= x;
		sum_in   <= s;
		do @(posedge clk); while (busy);
		pending_peaks.push_back(predict_peak(x, s));
		beats_sent++;
		if (!quiet && $urandom_range(0, 99) < 30) begin
			start <= 0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic test_directed();
		apply_setting(32'sd0, 32'sd65536, 32'sd65536);
		send_sample(32'sd0, 32'sd0);
		send_sample(32'sd65536, 32'sd0);
		send_sample(-32'sd65536, 32'sd100);
		send_sample(32'sd370800, 32'sd0);   // u^2 just beyond 32
		send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sh8000_0000);
		send_sample(32'sd0, 32'sh7FFF_FFFF);   // sum saturates high
		apply_setting(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
		send_sample(32'sh8000_0000, 32'sd0);
		send_sample(32'sh7FFF_FFFF, 32'sh8000_0000);   // sum saturates low
		send_sample(32'sd0, 32'sd0);
		apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000, 32'sd12345);
		send_sample(32'sh7FFF_FFFF, -32'sd1);
		apply_setting(32'sd1000, 32'sd0, 32'sd65536);   // zero width
		send_sample(32'sd1000, 32'sd77);
		send_sample(-32'sd5, 32'sh8000_0000);
		apply_setting(32'sd0, 32'sd1, -32'sd65536);
		send_sample(32'sd0, 32'sd0);
		send_sample(32'sd3, 32'sd0);
		send_sample(32'sd6, 32'sd0);
		wait_drained();
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);   // must be ignored
		cfg_we <= 0;
		send_sample(32'sd1, 32'sd0);
		send_sample(32'sd0, 32'sd5);
	endtask

	function automatic logic [31:0] pick_sample();
		longint hm, off, v;
		if ($urandom_range(0, 99) < 25) return $urandom;
		hm  = (mdl_hwidth < 0) ? -longint'(mdl_hwidth) : longint'(mdl_hwidth);
		off = (longint'($urandom_range(0, 14000)) - 7000) * hm / 1000;
		v   = longint'(mdl_center) + off + longint'($urandom_range(0, 3)) - 1;
		if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
		if (v < -(64'sd1 <<< 31)) v = -(64'sd1 <<< 31);
		return v[31:0];
	endfunction

	function automatic logic [31:0] pick_sum();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
			1: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
			2: return $urandom_range(0, 1 << 18) - (1 << 17);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_width();
		case ($urandom_range(0, 7))
			0: return $urandom_range(1, 64);
			1: return 32'h8000_0000;
			2: return 32'h7FFF_FFFF;
			3: return 0;
			4: return $urandom;
			default: return $urandom_range(1 << 12, 1 << 22) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	function automatic logic [31:0] pick_height();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return $urandom_range(1, 1 << 24) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	task automatic test_random();
		for (int ph = 0; ph < 9; ph++) begin
			quiet = (ph == 4);   // one long back-to-back stretch
			apply_setting($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22),
				pick_width(), pick_height());
			for (int k = 0; k < 200; k++) begin
				send_sample(pick_sample(), pick_sum());
				if (k == 100 && ph == 2) wait_drained();
			end
		end
		quiet = 0;
	endtask

	initial begin
		fill_pow_table();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		wait_drained();
		$display("tb: %0d sample beats over %0d register settings, %0d results checked",
			beats_sent, settings_used, beats_seen);
		if (mismatches == 0 && pending_peaks.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches, %0d results missing", mismatches,
				pending_peaks.size());
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: filelist.f
sv/gpe_pkg.sv
sv/gaussian_peak_evaluator.sv
test/tb.sv
